// File: hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITY_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITY_MAX = 2'd1;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_PEEK   = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  priority_req;
      logic [15:0] duration;
      logic [7:0]  tag;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        head_valid;
      logic [7:0]  out_priority;
      logic [15:0] out_duration;
      logic [7:0]  out_tag;
      logic [4:0]  occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] duration;
      logic [7:0]  tag;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_INS_CMP,
      S_INS_WR,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/stable_priority_queue.sv
`default_nettype none
// order: clear and failed requests go straight to the response state, pop and peek
// read the head entry first, and insert walks from the tail until the new entry is
// written; the walk moves one entry per cycle from the tail toward the head through
// the one-read one-write entry store
// throughput: one request at a time, the next held off by an insert walk or a result
// stall; the output register lets a new word in while a result waits
// reset: synchronous, empties the queue and sets the priority range to 0..255

module stable_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  spq_pkg::req_word_type        req_word,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output spq_pkg::rsp_word_type              rsp_word,
   input  wire                                csr_write_en,
   input  wire  [spq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [spq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import spq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      ptr_inc = (p == IW'(CAPACITY - 1)) ? '0 : p + IW'(1);
   endfunction

   function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
      ptr_dec = (p == '0) ? IW'(CAPACITY - 1) : p - IW'(1);
   endfunction

   function automatic rsp_word_type make_rsp(input logic [1:0] st, input logic hv,
                                             input entry_type e, input logic [CW-1:0] n);
      rsp_word_type r;
      r.status       = st;
      r.head_valid   = hv;
      r.out_priority = hv ? e.prio : '0;
      r.out_duration = hv ? e.duration : '0;
      r.out_tag      = hv ? e.tag : '0;
      r.occupancy    = 5'(n);
      make_rsp       = r;
   endfunction

   state_type        state_ff, state_in;
   req_word_type     req_ff, req_in;
   rsp_word_type     res_ff, res_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic [IW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [7:0]       prio_min_ff, prio_max_ff;

   entry_type        mem [CAPACITY];
   entry_type        rd_data_ff;
   logic             mem_we;
   logic [IW-1:0]    mem_waddr;
   entry_type        mem_wdata;
   logic [IW-1:0]    mem_raddr;
   entry_type        new_entry;
   entry_type        no_entry;

   assign new_entry = entry_type'{prio: req_ff.priority_req, duration: req_ff.duration,
                                  tag: req_ff.tag};
   assign no_entry  = '0;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_min_ff <= 8'd0;
         prio_max_ff <= 8'd255;
      end else if (csr_write_en) begin
         if (csr_index == CSR_PRIORITY_MIN) begin
            prio_min_ff <= csr_wdata;
         end else if (csr_index == CSR_PRIORITY_MAX) begin
            prio_max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
      cur_ff      <= cur_in;
      slot_ff     <= slot_in;
      left_ff     <= left_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = new_entry;
      mem_raddr    = ptr_dec(cur_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_word;
               unique case (req_word.req_type)
                  REQ_INSERT: begin
                     if (req_word.priority_req < prio_min_ff ||
                         req_word.priority_req > prio_max_ff) begin
                        res_in   = make_rsp(ST_RANGE, 1'b0, no_entry, count_ff);
                        state_in = S_RESP;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        res_in   = make_rsp(ST_FULL, 1'b0, no_entry, count_ff);
                        state_in = S_RESP;
                     end else if (count_ff == '0) begin
                        slot_in  = tail_ff;
                        state_in = S_INS_WR;
                     end else begin
                        // walk from the tail, moving larger priorities up one slot
                        slot_in   = tail_ff;
                        cur_in    = ptr_dec(tail_ff);
                        mem_raddr = ptr_dec(tail_ff);
                        left_in   = count_ff;
                        state_in  = S_INS_CMP;
                     end
                  end
                  REQ_POP, REQ_PEEK: begin
                     if (count_ff == '0) begin
                        res_in   = make_rsp(ST_EMPTY, 1'b0, no_entry, count_ff);
                        state_in = S_RESP;
                     end else begin
                        mem_raddr = head_ff;
                        state_in  = S_HEAD;
                     end
                  end
                  REQ_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     res_in   = make_rsp(ST_OK, 1'b0, no_entry, '0);
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_HEAD: begin
            if (req_ff.req_type == REQ_POP) begin
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - CW'(1);
               res_in   = make_rsp(ST_OK, 1'b1, rd_data_ff, count_ff - CW'(1));
            end else begin
               res_in   = make_rsp(ST_OK, 1'b1, rd_data_ff, count_ff);
            end
            state_in = S_RESP;
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (rd_data_ff.prio > req_ff.priority_req) begin
               mem_wdata = rd_data_ff;
               slot_in   = cur_ff;
               if (left_ff == CW'(1)) begin
                  state_in = S_INS_WR;
               end else begin
                  cur_in  = ptr_dec(cur_ff);
                  left_in = left_ff - CW'(1);
               end
            end else begin
               count_in = count_ff + CW'(1);
               tail_in  = ptr_inc(tail_ff);
               res_in   = make_rsp(ST_OK, 1'b0, no_entry, count_ff + CW'(1));
               state_in = S_RESP;
            end
         end
         S_INS_WR: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            tail_in  = ptr_inc(tail_ff);
            res_in   = make_rsp(ST_OK, 1'b0, no_entry, count_ff + CW'(1));
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ring bookkeeping: tail is always head plus count around the ring
   logic [CW:0] ring_sum;
   logic [CW:0] ring_wrap;
   assign ring_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign ring_wrap = (ring_sum >= (CW + 1)'(CAPACITY)) ?
                      ring_sum - (CW + 1)'(CAPACITY) : ring_sum;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      IW'(ring_wrap) == tail_ff)
      else $error("tail pointer out of step with head and count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.req_type == REQ_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the queue");

   a_head_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.head_valid |-> rsp_word.status == ST_OK)
      else $error("head word returned with a failing status");

   a_walk_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_CMP |-> left_ff != '0 && count_ff != CW'(CAPACITY))
      else $error("insert walk past the stored entries");

endmodule

`default_nettype wire
